// ===== hw/rtl/cube_face_direction_texel_macros.svh =====
// Assertion macros shared by the cube face texel RTL.
`ifndef CUBE_FACE_DIRECTION_TEXEL_MACROS_SVH
`define CUBE_FACE_DIRECTION_TEXEL_MACROS_SVH

// Assert an implication on the rising clock edge, off during reset.
`define CFDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Assert a next-cycle implication on the rising clock edge, off during reset.
`define CFDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/cfdt_pkg.sv =====
// Package with transaction types and face codes of the cube face texel block.
package cfdt_pkg;

  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  localparam int KBITS = 8;

  typedef struct packed {
    logic [2:0] face;
    logic [9:0] column;
    logic [9:0] row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] intensity;
    logic       coord_error;
  } out_item_t;

endpackage

// ===== hw/rtl/cube_face_direction_texel.sv =====
// Top level of the cube face texel block: pipelined normalization cube map texel.
// One texel per clock while the output is not stalled; each result passes through the range
// check, squares, distance, square of the numerator, eight stages that each settle one bit
// of the quotient floor by add and compare, and the output register.
// The whole pipeline holds while a result waits on out_ready. face_size is written through
// the cfg channel, which is always ready; values above MAX_SIZE act as MAX_SIZE.
`include "cube_face_direction_texel_macros.svh"

module cube_face_direction_texel #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfdt_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output cfdt_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [10:0]          cfg_data
);

  localparam int SW  = $clog2(MAX_SIZE + 1);
  localparam int CW  = ((SW > 10) ? SW : 10) + 1;
  localparam int MW  = CW + 1;
  localparam int AW  = MW + 7;
  localparam int DW  = 2 * CW + 2;
  localparam int WW  = DW + 20;
  localparam int KB  = cfdt_pkg::KBITS;

  logic [10:0] face_size;
  logic        en;
  logic [SW-1:0] s_sat;
  logic [SW-1:0] h;

  // Hold the face size register.
  always_ff @(posedge clk) begin
    if (rst) begin
      face_size <= 11'd64;
    end else if (cfg_valid) begin
      face_size <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // Advance every stage when the output register is free or being taken.
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    if ({21'd0, face_size} > 32'(MAX_SIZE)) begin
      s_sat = SW'(MAX_SIZE);
    end else begin
      s_sat = SW'(face_size);
    end
    h = s_sat >> 1;
  end

  // Stage 1: range check and centered coordinates.
  logic                 v1, err1;
  logic [2:0]           face1;
  logic [SW-1:0]        s1;
  logic signed [CW-1:0] x1, y1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      err1  <= (in_data.face > cfdt_pkg::FACE_NZ) ||
               (CW'(in_data.column) >= CW'(s_sat)) || (CW'(in_data.row) >= CW'(s_sat));
      face1 <= in_data.face;
      s1    <= s_sat;
      x1    <= $signed(CW'(in_data.column)) - $signed(CW'(h));
      y1    <= $signed(CW'(in_data.row)) - $signed(CW'(h));
    end
  end

  // Stage 2: squares and signed numerator magnitude.
  logic                 v2, err2, neg2;
  logic [MW-1:0]        mag2;
  logic [DW-1:0]        xx2, yy2, s42;
  logic [CW-1:0]        ax, ay;
  logic [MW-1:0]        mag_c;
  logic                 neg_c;
  logic signed [2*CW-1:0] xsq, ysq;
  logic [2*SW-1:0]      ssq;

  always_comb begin
    ax    = x1[CW-1] ? CW'(-x1) : CW'(x1);
    ay    = y1[CW-1] ? CW'(-y1) : CW'(y1);
    xsq   = x1 * x1;
    ysq   = y1 * y1;
    ssq   = (2*SW)'(s1) * (2*SW)'(s1);
    mag_c = MW'(0);
    neg_c = 1'b0;
    unique case (face1)
      cfdt_pkg::FACE_PX: begin
        mag_c = {ax, 1'b0};
        neg_c = !x1[CW-1] && (x1 != '0);
      end
      cfdt_pkg::FACE_NX: begin
        mag_c = {ax, 1'b0};
        neg_c = x1[CW-1];
      end
      cfdt_pkg::FACE_PY: begin
        mag_c = {ay, 1'b0};
        neg_c = y1[CW-1];
      end
      cfdt_pkg::FACE_NY: begin
        mag_c = {ay, 1'b0};
        neg_c = !y1[CW-1] && (y1 != '0);
      end
      cfdt_pkg::FACE_PZ: begin
        mag_c = MW'(s1);
        neg_c = 1'b0;
      end
      default: begin
        mag_c = MW'(s1);
        neg_c = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      err2 <= err1;
      neg2 <= neg_c;
      mag2 <= mag_c;
      xx2  <= DW'($unsigned(xsq));
      yy2  <= DW'($unsigned(ysq));
      s42  <= DW'(ssq >> 2);
    end
  end

  // Stage 3: distance and scaled numerator.
  logic          v3, err3, neg3, zero3;
  logic [DW-1:0] d3;
  logic [AW-1:0] a3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      err3  <= err2;
      neg3  <= neg2;
      zero3 <= (mag2 == '0);
      d3    <= s42 + xx2 + yy2;
      a3    <= AW'(mag2) * AW'(127);
    end
  end

  // Stage 4: square of the scaled numerator.
  logic          v4, err4, neg4, zero4;
  logic [DW-1:0] d4;
  logic [WW-1:0] a24;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      err4  <= err3;
      neg4  <= neg3;
      zero4 <= zero3;
      d4    <= d3;
      a24   <= WW'((2*AW)'(a3) * (2*AW)'(a3));
    end
  end

  // Quotient stages: settle one bit of k per stage, tracking P = d*k*k and Q = d*k.
  logic          vs   [0:KB];
  logic          errs [0:KB];
  logic          negs [0:KB];
  logic          zeros[0:KB];
  logic [DW-1:0] ds   [0:KB];
  logic [WW-1:0] a2s  [0:KB];
  logic [WW-1:0] ps   [0:KB];
  logic [WW-1:0] qs   [0:KB];
  logic [KB-1:0] ks   [0:KB];

  assign vs[0]    = v4;
  assign errs[0]  = err4;
  assign negs[0]  = neg4;
  assign zeros[0] = zero4;
  assign ds[0]    = d4;
  assign a2s[0]   = a24;
  assign ps[0]    = '0;
  assign qs[0]    = '0;
  assign ks[0]    = '0;

  for (genvar i = 0; i < KB; i++) begin : g_bit
    localparam int J = KB - 1 - i;
    logic [WW-1:0]  t;
    logic [WW+1:0]  t4;
    logic           fits;

    always_comb begin
      t    = ps[i] + (qs[i] << (J + 1)) + (WW'(ds[i]) << (2 * J));
      t4   = {t, 2'b00};
      fits = t4 <= (WW+2)'(a2s[i]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vs[i+1] <= 1'b0;
      end else if (en) begin
        vs[i+1] <= vs[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        errs[i+1]  <= errs[i];
        negs[i+1]  <= negs[i];
        zeros[i+1] <= zeros[i];
        ds[i+1]    <= ds[i];
        a2s[i+1]   <= a2s[i];
        ps[i+1]    <= fits ? t : ps[i];
        qs[i+1]    <= fits ? (qs[i] + (WW'(ds[i]) << J)) : qs[i];
        ks[i+1]    <= fits ? (ks[i] | KB'(1 << J)) : ks[i];
      end
    end
  end

  // Final: apply sign and exactness, clamp, and load the output register.
  logic [7:0]   intensity_next;
  logic         exact;
  logic [KB-1:0] kf;

  always_comb begin
    kf    = ks[KB];
    exact = {ps[KB], 2'b00} == (WW+2)'(a2s[KB]);
    priority if (errs[KB]) begin
      intensity_next = 8'd0;
    end else if (zeros[KB]) begin
      intensity_next = 8'd128;
    end else if (!negs[KB]) begin
      intensity_next = kf[7] ? 8'd255 : {1'b1, kf[6:0]};
    end else if (exact) begin
      intensity_next = (kf > 8'd128) ? 8'd0 : 8'(9'd128 - {1'b0, kf});
    end else begin
      intensity_next = (kf > 8'd127) ? 8'd0 : 8'(9'd127 - {1'b0, kf});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vs[KB];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.intensity   <= intensity_next;
      out_data.coord_error <= errs[KB];
    end
  end

  // Check output behavior.
  `CFDT_ASSERT_IMP(a_err_zero, clk, rst, out_valid && out_data.coord_error, out_data.intensity == 8'd0, "error result with nonzero intensity")
  `CFDT_ASSERT_NXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `CFDT_ASSERT_NXT(a_stall_pipe, clk, rst, !en, $stable(vs[KB]) && $stable(v1), "pipeline moved during stall")

endmodule

// ===== tb/cube_face_direction_texel_test.sv =====
// Testbench for the cube face texel block: directed table, random traffic, scoreboard.
`timescale 1ns / 100ps

module cube_face_direction_texel_test;

  localparam int LIMIT_SIZE = 1024;
  localparam int PIPE_DEPTH = 14;

  typedef struct {
    cfdt_pkg::in_item_t   item;
    logic                 known;
    cfdt_pkg::out_item_t  result;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cfdt_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cfdt_pkg::out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [10:0] cfg_data = '0;

  logic [10:0] size_reg;
  cfdt_pkg::out_item_t texel_queue[$];
  int errors = 0;
  bit long_hold = 1'b0;

  cube_face_direction_texel dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Compute the expected texel from the current face size.
  function automatic cfdt_pkg::out_item_t predict_texel(cfdt_pkg::in_item_t it);
    cfdt_pkg::out_item_t r;
    longint s, h, x, y, d, m, a, a2, lo, hi, mid, q, v;
    r = '0;
    s = (size_reg > LIMIT_SIZE) ? LIMIT_SIZE : size_reg;
    if (it.face > cfdt_pkg::FACE_NZ || it.column >= s || it.row >= s) begin
      r.coord_error = 1'b1;
      return r;
    end
    h = s / 2;
    x = longint'(it.column) - h;
    y = longint'(it.row) - h;
    d = (s * s) / 4 + x * x + y * y;
    unique case (it.face)
      cfdt_pkg::FACE_PX: m = -2 * x;
      cfdt_pkg::FACE_NX: m = 2 * x;
      cfdt_pkg::FACE_PY: m = 2 * y;
      cfdt_pkg::FACE_NY: m = -2 * y;
      cfdt_pkg::FACE_PZ: m = s;
      default: m = -s;
    endcase
    a = (m < 0 ? -m : m) * 127;
    if (d == 0) begin
      r.intensity = (a == 0) ? 8'd128 : (m > 0 ? 8'd255 : 8'd0);
      return r;
    end
    a2 = a * a;
    lo = 0;
    hi = 255;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (4 * d * mid * mid <= a2) lo = mid;
      else hi = mid - 1;
    end
    if (m >= 0) q = lo;
    else if (4 * d * lo * lo == a2) q = -lo;
    else q = -lo - 1;
    v = 128 + q;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    r.intensity = v[7:0];
    return r;
  endfunction

  // Offer one transaction, with an occasional random gap first when gaps is set, and queue its expected texel.
  // The caller drops valid once the run of transactions ends.
  task automatic send_texel(cfdt_pkg::in_item_t it, bit known, cfdt_pkg::out_item_t want,
                            bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    texel_queue.push_back(known ? want : predict_texel(it));
  endtask

  // Write face_size once the pipeline has drained.
  task automatic write_size(logic [10:0] val);
    while (texel_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    size_reg = val;
    cfg_valid <= 1'b0;
  endtask

  function automatic cfdt_pkg::in_item_t rand_item(int s);
    cfdt_pkg::in_item_t it;
    int lim;
    lim = (s > LIMIT_SIZE) ? LIMIT_SIZE : s;
    it.face = 3'(($urandom_range(0, 15) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0 || lim == 0) begin
      it.column = 10'($urandom);
      it.row = 10'($urandom);
    end else begin
      it.column = 10'($urandom_range(0, lim - 1));
      it.row = 10'($urandom_range(0, lim - 1));
    end
    return it;
  endfunction

  // Receiver: random stalls, plus one long hold-off to back up the pipeline.
  always @(posedge clk) begin
    if (rst || long_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
  end

  initial begin
    @(negedge rst);
    repeat (300) @(posedge clk);
    long_hold = 1'b1;
    repeat (80) @(posedge clk);
    long_hold = 1'b0;
  end

  // Compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (texel_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        cfdt_pkg::out_item_t want;
        want = texel_queue.pop_front();
        if (out_data.intensity !== want.intensity) begin
          $display("%0t: intensity expected %0d actual %0d", $time, want.intensity,
                   out_data.intensity);
          errors++;
        end
        if (out_data.coord_error !== want.coord_error) begin
          $display("%0t: coord_error expected %0b actual %0b", $time, want.coord_error,
                   out_data.coord_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    int sizes[8];
    int n;
    size_reg = 11'd64;
    sizes = '{1, 2, 3, 2047, 1024, 5, 64, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows at reset size 64; center is (32, 32).
    rows.push_back('{'{cfdt_pkg::FACE_PX, 10'd32, 10'd32}, 1'b1, '{8'd128, 1'b0}});
    rows.push_back('{'{cfdt_pkg::FACE_NY, 10'd32, 10'd32}, 1'b1, '{8'd128, 1'b0}});
    rows.push_back('{'{cfdt_pkg::FACE_PZ, 10'd32, 10'd32}, 1'b1, '{8'd255, 1'b0}});
    rows.push_back('{'{cfdt_pkg::FACE_NZ, 10'd32, 10'd32}, 1'b1, '{8'd1, 1'b0}});
    rows.push_back('{'{3'd6, 10'd0, 10'd0}, 1'b1, '{8'd0, 1'b1}});
    rows.push_back('{'{3'd7, 10'd5, 10'd5}, 1'b1, '{8'd0, 1'b1}});
    rows.push_back('{'{cfdt_pkg::FACE_PX, 10'd64, 10'd0}, 1'b1, '{8'd0, 1'b1}});
    rows.push_back('{'{cfdt_pkg::FACE_NX, 10'd0, 10'd64}, 1'b1, '{8'd0, 1'b1}});
    rows.push_back('{'{cfdt_pkg::FACE_PY, 10'd1023, 10'd1023}, 1'b1, '{8'd0, 1'b1}});
    rows.push_back('{'{cfdt_pkg::FACE_PX, 10'd0, 10'd0}, 1'b0, '0});
    rows.push_back('{'{cfdt_pkg::FACE_NX, 10'd63, 10'd63}, 1'b0, '0});
    rows.push_back('{'{cfdt_pkg::FACE_PY, 10'd0, 10'd63}, 1'b0, '0});
    rows.push_back('{'{cfdt_pkg::FACE_NY, 10'd63, 10'd0}, 1'b0, '0});
    rows.push_back('{'{cfdt_pkg::FACE_PZ, 10'd0, 10'd63}, 1'b0, '0});
    rows.push_back('{'{cfdt_pkg::FACE_NZ, 10'd63, 10'd0}, 1'b0, '0});
    foreach (rows[i]) send_texel(rows[i].item, rows[i].known, rows[i].result, 1'b0);
    in_valid <= 1'b0;

    // Single-texel face: saturation on the Z faces, zero component elsewhere.
    write_size(11'd1);
    send_texel('{cfdt_pkg::FACE_PZ, 10'd0, 10'd0}, 1'b1, '{8'd255, 1'b0}, 1'b0);
    send_texel('{cfdt_pkg::FACE_NZ, 10'd0, 10'd0}, 1'b1, '{8'd0, 1'b0}, 1'b0);
    send_texel('{cfdt_pkg::FACE_PX, 10'd0, 10'd0}, 1'b1, '{8'd128, 1'b0}, 1'b0);
    send_texel('{cfdt_pkg::FACE_NY, 10'd0, 10'd0}, 1'b1, '{8'd128, 1'b0}, 1'b0);
    send_texel('{cfdt_pkg::FACE_PY, 10'd1, 10'd0}, 1'b1, '{8'd0, 1'b1}, 1'b0);
    in_valid <= 1'b0;

    // Random phases across sizes, extremes included; the last phase, at size 0, is shorter.
    for (int p = 0; p < 8; p++) begin
      write_size(sizes[p][10:0]);
      n = (p == 7) ? 60 : 190;
      for (int i = 0; i < n; i++) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && i < n; b++, i++) begin
          in_valid <= 1'b1;
          in_data <= rand_item(size_reg);
          @(posedge clk);
          while (!in_ready) @(posedge clk);
          texel_queue.push_back(predict_texel(in_data));
        end
        i--;
        if ($urandom_range(0, 1) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
    end

    while (texel_queue.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 6) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ===== cube_face_direction_texel.f =====
+incdir+hw/rtl
hw/rtl/cfdt_pkg.sv
hw/rtl/cube_face_direction_texel.sv
tb/cube_face_direction_texel_test.sv
